// File: sv/gru_cell_step_macros.svh
// Assertion macros used by the checker of the GRU step block.
`ifndef GRU_CELL_STEP_MACROS_SVH
`define GRU_CELL_STEP_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define GCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define GCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/gcs_pkg.sv
package gcs_pkg;

    typedef logic signed [15:0] t_word;

    localparam int ACC_W  = 40;
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // Input operation codes.
    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_FEATURE = 2'd1;
    localparam logic [1:0] OP_HIDDEN  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_INPUT_LEN  = 1'b0;
    localparam logic REG_HIDDEN_LEN = 1'b1;

    // Gate numbers.
    localparam logic [1:0] GATE_Z = 2'd0;
    localparam logic [1:0] GATE_R = 2'd1;
    localparam logic [1:0] GATE_C = 2'd2;

    // Kind of word inside a gate bank.
    localparam logic [1:0] KIND_W = 2'd0;
    localparam logic [1:0] KIND_U = 2'd1;
    localparam logic [1:0] KIND_B = 2'd2;

    // Activation break points, 16 fraction bits, steps of 0.25 from 0 to 8.
    localparam logic [16:0] SIG_TAB [33] = '{
        17'd32768, 17'd36843, 17'd40793, 17'd44511, 17'd47911, 17'd50941,
        17'd53581, 17'd55834, 17'd57724, 17'd59287, 17'd60565, 17'd61598,
        17'd62428, 17'd63090, 17'd63615, 17'd64030, 17'd64357, 17'd64614,
        17'd64816, 17'd64974, 17'd65097, 17'd65194, 17'd65269, 17'd65328,
        17'd65374, 17'd65410, 17'd65438, 17'd65459, 17'd65476, 17'd65489,
        17'd65500, 17'd65508, 17'd65514
    };

    localparam logic [16:0] TANH_TAB [33] = '{
        17'd0,     17'd16051, 17'd30285, 17'd41625, 17'd49912, 17'd55593,
        17'd59320, 17'd61694, 17'd63179, 17'd64096, 17'd64659, 17'd65003,
        17'd65212, 17'd65339, 17'd65417, 17'd65464, 17'd65492, 17'd65509,
        17'd65520, 17'd65526, 17'd65530, 17'd65532, 17'd65534, 17'd65535,
        17'd65535, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536
    };

    // Table point lookup; odd selects tanh, otherwise sigmoid.
    function automatic logic [16:0] act_tab(input logic odd, input logic [5:0] idx);
        logic [16:0] v;
        if (idx > 6'd32) begin
            v = '0;
        end else if (odd) begin
            v = TANH_TAB[idx];
        end else begin
            v = SIG_TAB[idx];
        end
        return v;
    endfunction

endpackage

// File: sv/gcs_in_if.sv
interface gcs_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [3:0]        bank;
    logic [3:0]        row;
    logic [3:0]        col;
    logic signed [15:0] value;

    modport source (output valid, output op, output bank, output row, output col,
                    output value, input ready);
    modport sink (input valid, input op, input bank, input row, input col,
                  input value, output ready);
endinterface

// File: sv/gcs_out_if.sv
interface gcs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] hidden_value;
    logic [3:0]         unit_index;
    logic               last;

    modport source (output valid, output hidden_value, output unit_index,
                    output last, input ready);
    modport sink (input valid, input hidden_value, input unit_index,
                  input last, output ready);
endinterface

// File: sv/gru_cell_step.sv
// Non-step words (weights, biases, hidden values, non-final features) are stored while idle.
// A final feature starts a step over I features and H units, which runs all of its
// products through the single shared multiplier.
// Results leave one word per cycle while the output is ready, after the step; input is not ready meanwhile.
// Synchronous active-low reset clears control, sets lengths to 16 and clears hidden values to 0.
module gru_cell_step #(
    parameter int HIDDEN_MAX = 16,
    parameter int INPUT_MAX  = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcs_in_if.sink     i_in,
    gcs_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [4:0] i_cfg_wdata
);

    localparam int IN_LIM  = (INPUT_MAX < 16) ? INPUT_MAX : 16;
    localparam int HID_LIM = (HIDDEN_MAX < 16) ? HIDDEN_MAX : 16;
    localparam int IAW     = (INPUT_MAX > 1) ? $clog2(INPUT_MAX) : 1;
    localparam int HAW     = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
    localparam int W_DEPTH = 3 * HIDDEN_MAX * INPUT_MAX;
    localparam int U_DEPTH = 3 * HIDDEN_MAX * HIDDEN_MAX;
    localparam int B_DEPTH = 3 * HIDDEN_MAX;
    localparam int W_AW    = $clog2(W_DEPTH);
    localparam int U_AW    = $clog2(U_DEPTH);
    localparam int B_AW    = $clog2(B_DEPTH);
    localparam int SEG_SH  = FRAC_BITS - 2;
    localparam int ACT_LIM = (8 << FRAC_BITS) - 1;
    localparam int FR_MASK = (1 << SEG_SH) - 1;
    localparam int ACC_W   = gcs_pkg::ACC_W;
    localparam int MUL_W   = gcs_pkg::MUL_W;
    localparam int PROD_W  = gcs_pkg::PROD_W;

    localparam logic signed [MUL_W-1:0] ONE_Q  = MUL_W'(1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1 << (FRAC_BITS - 1));

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAC   = 4'd1;
    localparam logic [3:0] ST_DRAIN = 4'd2;
    localparam logic [3:0] ST_ACT0  = 4'd3;
    localparam logic [3:0] ST_ACT1  = 4'd4;
    localparam logic [3:0] ST_ACT2  = 4'd5;
    localparam logic [3:0] ST_RH0   = 4'd6;
    localparam logic [3:0] ST_RH1   = 4'd7;
    localparam logic [3:0] ST_BL0   = 4'd8;
    localparam logic [3:0] ST_BL1   = 4'd9;
    localparam logic [3:0] ST_BL2   = 4'd10;
    localparam logic [3:0] ST_EMIT  = 4'd11;

    // Round half up to the word scale, then saturate.
    function automatic gcs_pkg::t_word round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = (v + HALF) >>> FRAC_BITS;
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return 16'(s);
    endfunction

    logic [3:0]             r_state, n_state;
    logic [4:0]             r_input_len, r_hidden_len;
    gcs_pkg::t_word         r_hid  [HIDDEN_MAX];
    gcs_pkg::t_word         r_feat [INPUT_MAX];
    gcs_pkg::t_word         r_zg   [HIDDEN_MAX];
    gcs_pkg::t_word         r_rg   [HIDDEN_MAX];
    gcs_pkg::t_word         r_rh   [HIDDEN_MAX];
    gcs_pkg::t_word         r_nw   [HIDDEN_MAX];
    gcs_pkg::t_word         r_cand;
    logic [1:0]             r_g;
    logic [3:0]             r_i;
    logic [5:0]             r_t;
    logic                   r_v1, r_v2, r_first1, r_selu1;
    gcs_pkg::t_word         r_b1;
    logic signed [ACC_W-1:0] r_acc;
    gcs_pkg::t_word         r_x;
    logic [16:0]            r_base;
    logic                   r_neg;
    logic                   r_ovld;
    gcs_pkg::t_word         r_oval;
    logic [3:0]             r_oidx;
    logic                   r_olast;

    logic [4:0]  ni, nh;
    logic [5:0]  nterm, hidx;
    logic        in_acc, in_start, last_unit, is_w, load_out, odd;
    logic [HAW-1:0] ix;
    logic [1:0]  wg, wkind;
    logic        bank_ok;
    logic        w_we, u_we, b_we;
    logic [15:0] w_rdata, u_rdata, b_rdata;
    logic [W_AW-1:0] w_waddr, w_raddr;
    logic [U_AW-1:0] u_waddr, u_raddr;
    logic [B_AW-1:0] b_waddr, b_raddr;
    gcs_pkg::t_word  opb;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [16:0] xs;
    logic [16:0] abs_x, a_cl, act_fr, act_base, act_diff;
    logic [5:0]  act_seg;
    logic [18:0] act_y;
    logic [16:0] act_q;
    gcs_pkg::t_word act_out;

    // Lengths in use, clamped to at least one and at most the store.
    always_comb begin
        if (r_input_len == 5'd0) begin
            ni = 5'd1;
        end else if (int'(r_input_len) > IN_LIM) begin
            ni = 5'(IN_LIM);
        end else begin
            ni = r_input_len;
        end
        if (r_hidden_len == 5'd0) begin
            nh = 5'd1;
        end else if (int'(r_hidden_len) > HID_LIM) begin
            nh = 5'(HID_LIM);
        end else begin
            nh = r_hidden_len;
        end
    end

    assign nterm     = {1'b0, ni} + {1'b0, nh};
    assign last_unit = ({1'b0, r_i} == (nh - 5'd1));
    assign ix        = HAW'(r_i);
    assign odd       = (r_g == gcs_pkg::GATE_C);
    assign in_acc    = i_in.valid && i_in.ready;
    assign in_start  = in_acc && (i_in.op == gcs_pkg::OP_FEATURE) &&
                       (int'(i_in.col) < INPUT_MAX) && ({1'b0, i_in.col} == (ni - 5'd1));

    // Bank decode into gate and word kind.
    always_comb begin
        bank_ok = 1'b1;
        wg      = gcs_pkg::GATE_Z;
        wkind   = gcs_pkg::KIND_W;
        case (i_in.bank)
            4'd0: begin wg = gcs_pkg::GATE_Z; wkind = gcs_pkg::KIND_W; end
            4'd1: begin wg = gcs_pkg::GATE_Z; wkind = gcs_pkg::KIND_U; end
            4'd2: begin wg = gcs_pkg::GATE_Z; wkind = gcs_pkg::KIND_B; end
            4'd3: begin wg = gcs_pkg::GATE_R; wkind = gcs_pkg::KIND_W; end
            4'd4: begin wg = gcs_pkg::GATE_R; wkind = gcs_pkg::KIND_U; end
            4'd5: begin wg = gcs_pkg::GATE_R; wkind = gcs_pkg::KIND_B; end
            4'd6: begin wg = gcs_pkg::GATE_C; wkind = gcs_pkg::KIND_W; end
            4'd7: begin wg = gcs_pkg::GATE_C; wkind = gcs_pkg::KIND_U; end
            4'd8: begin wg = gcs_pkg::GATE_C; wkind = gcs_pkg::KIND_B; end
            default: bank_ok = 1'b0;
        endcase
    end

    // Weight and bias store writes.
    always_comb begin
        logic wr_ok;
        wr_ok = in_acc && (i_in.op == gcs_pkg::OP_WEIGHT) && bank_ok &&
                (int'(i_in.row) < HIDDEN_MAX);
        w_we  = wr_ok && (wkind == gcs_pkg::KIND_W) && (int'(i_in.col) < INPUT_MAX);
        u_we  = wr_ok && (wkind == gcs_pkg::KIND_U) && (int'(i_in.col) < HIDDEN_MAX);
        b_we  = wr_ok && (wkind == gcs_pkg::KIND_B);
    end

    assign w_waddr = W_AW'((int'(wg) * HIDDEN_MAX + int'(i_in.row)) * INPUT_MAX +
                           int'(i_in.col));
    assign u_waddr = U_AW'((int'(wg) * HIDDEN_MAX + int'(i_in.row)) * HIDDEN_MAX +
                           int'(i_in.col));
    assign b_waddr = B_AW'(int'(wg) * HIDDEN_MAX + int'(i_in.row));

    // Term reads of the multiply-accumulate pass.
    assign is_w    = (r_t < {1'b0, ni});
    assign hidx    = r_t - {1'b0, ni};
    assign w_raddr = W_AW'((int'(r_g) * HIDDEN_MAX + int'(r_i)) * INPUT_MAX + int'(r_t));
    assign u_raddr = U_AW'((int'(r_g) * HIDDEN_MAX + int'(r_i)) * HIDDEN_MAX + int'(hidx));
    assign b_raddr = B_AW'(int'(r_g) * HIDDEN_MAX + int'(r_i));

    always_comb begin
        if (is_w) begin
            opb = r_feat[IAW'(r_t)];
        end else if (odd) begin
            opb = r_rh[HAW'(hidx)];
        end else begin
            opb = r_hid[HAW'(hidx)];
        end
    end

    gcs_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_w_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gcs_ram #(.WIDTH(16), .DEPTH(U_DEPTH)) u_u_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (i_in.value),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    gcs_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (i_in.value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // Activation: segment and fraction from the rounded gate sum.
    always_comb begin
        xs       = 17'(r_x);
        abs_x    = r_x[15] ? 17'(-xs) : 17'(xs);
        a_cl     = (int'(abs_x) > ACT_LIM) ? 17'(ACT_LIM) : abs_x;
        act_seg  = 6'(a_cl >> SEG_SH);
        act_fr   = a_cl & 17'(FR_MASK);
        act_base = gcs_pkg::act_tab(odd, act_seg);
        act_diff = gcs_pkg::act_tab(odd, act_seg + 6'd1) - act_base;
        act_y    = 19'(r_base) + 19'(mul_p >>> SEG_SH);
        act_q    = 17'((act_y + 19'(1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS));
        if (!r_neg) begin
            act_out = 16'(act_q);
        end else if (odd) begin
            act_out = 16'(-signed'(act_q));
        end else begin
            act_out = 16'(ONE_Q - signed'(act_q));
        end
    end

    // Operand select for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_v1) begin
            mul_a = MUL_W'(signed'(r_selu1 ? u_rdata : w_rdata));
            mul_b = MUL_W'(r_b1);
        end else begin
            case (r_state)
                ST_ACT1: begin
                    mul_a = signed'(act_diff);
                    mul_b = signed'(act_fr);
                end
                ST_RH0: begin
                    mul_a = MUL_W'(r_rg[ix]);
                    mul_b = MUL_W'(r_hid[ix]);
                end
                ST_BL0: begin
                    mul_a = MUL_W'(r_zg[ix]);
                    mul_b = MUL_W'(r_hid[ix]);
                end
                ST_BL1: begin
                    mul_a = ONE_Q - MUL_W'(r_zg[ix]);
                    mul_b = MUL_W'(r_cand);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    gcs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign load_out = (r_state == ST_EMIT) && (!r_ovld || o_out.ready);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_start) n_state = ST_MAC;
            ST_MAC:   if (r_t == nterm - 6'd1) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_v1 && !r_v2) n_state = ST_ACT0;
            ST_ACT0:  n_state = ST_ACT1;
            ST_ACT1:  n_state = ST_ACT2;
            ST_ACT2: begin
                if (r_g == gcs_pkg::GATE_C) begin
                    n_state = ST_BL0;
                end else if (r_g == gcs_pkg::GATE_R && last_unit) begin
                    n_state = ST_RH0;
                end else begin
                    n_state = ST_MAC;
                end
            end
            ST_RH0:   n_state = ST_RH1;
            ST_RH1:   n_state = last_unit ? ST_MAC : ST_RH0;
            ST_BL0:   n_state = ST_BL1;
            ST_BL1:   n_state = ST_BL2;
            ST_BL2:   n_state = last_unit ? ST_EMIT : ST_MAC;
            ST_EMIT:  if (load_out && last_unit) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_input_len  <= 5'd16;
            r_hidden_len <= 5'd16;
            r_g          <= gcs_pkg::GATE_Z;
            r_i          <= '0;
            r_t          <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_ovld       <= 1'b0;
            for (int k = 0; k < HIDDEN_MAX; k++) begin
                r_hid[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == ST_MAC);
            r_v2    <= r_v1;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    gcs_pkg::REG_INPUT_LEN:  r_input_len  <= i_cfg_wdata;
                    gcs_pkg::REG_HIDDEN_LEN: r_hidden_len <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // Hidden vector: initial writes while idle, new values while emitting.
            if (in_acc && i_in.op == gcs_pkg::OP_HIDDEN && int'(i_in.row) < HIDDEN_MAX) begin
                r_hid[HAW'(i_in.row)] <= i_in.value;
            end
            if (load_out) begin
                r_hid[ix] <= r_nw[ix];
            end

            // Unit, gate and term counters.
            case (r_state)
                ST_IDLE: begin
                    r_g <= gcs_pkg::GATE_Z;
                    r_i <= '0;
                    r_t <= '0;
                end
                ST_MAC: begin
                    r_t <= (r_t == nterm - 6'd1) ? 6'd0 : r_t + 6'd1;
                end
                ST_ACT2: begin
                    if (r_g == gcs_pkg::GATE_Z) begin
                        r_g <= gcs_pkg::GATE_R;
                    end else if (r_g == gcs_pkg::GATE_R) begin
                        r_g <= gcs_pkg::GATE_Z;
                        r_i <= last_unit ? 4'd0 : r_i + 4'd1;
                    end
                end
                ST_RH1: begin
                    r_i <= last_unit ? 4'd0 : r_i + 4'd1;
                    if (last_unit) r_g <= gcs_pkg::GATE_C;
                end
                ST_BL2: begin
                    r_i <= last_unit ? 4'd0 : r_i + 4'd1;
                end
                ST_EMIT: begin
                    if (load_out) r_i <= last_unit ? 4'd0 : r_i + 4'd1;
                end
                default: ;
            endcase

            // Output register.
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.op == gcs_pkg::OP_FEATURE && int'(i_in.col) < INPUT_MAX) begin
            r_feat[IAW'(i_in.col)] <= i_in.value;
        end

        // Term pipeline: operand fetch, multiply, accumulate.
        r_first1 <= (r_t == 6'd0);
        r_selu1  <= !is_w;
        r_b1     <= opb;
        if (r_v2) begin
            r_acc <= r_acc + ACC_W'(mul_p);
        end
        if (r_v1 && r_first1) begin
            r_acc <= ACC_W'(signed'(b_rdata)) <<< FRAC_BITS;
        end

        case (r_state)
            ST_ACT0: r_x <= round_sat(r_acc);
            ST_ACT1: begin
                r_base <= act_base;
                r_neg  <= r_x[15];
            end
            ST_ACT2: begin
                case (r_g)
                    gcs_pkg::GATE_Z: r_zg[ix] <= act_out;
                    gcs_pkg::GATE_R: r_rg[ix] <= act_out;
                    default:         r_cand   <= act_out;
                endcase
            end
            ST_RH1: r_rh[ix] <= round_sat(ACC_W'(mul_p));
            ST_BL1: r_acc <= ACC_W'(mul_p);
            ST_BL2: r_nw[ix] <= round_sat(r_acc + ACC_W'(mul_p));
            default: ;
        endcase

        if (load_out) begin
            r_oval  <= r_nw[ix];
            r_oidx  <= r_i;
            r_olast <= last_unit;
        end
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_ovld;
    assign o_out.hidden_value = r_oval;
    assign o_out.unit_index   = r_oidx;
    assign o_out.last         = r_olast;

endmodule

// File: sv/gcs_ram.sv
module gcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/gcs_mul.sv
module gcs_mul (
    input  logic                                i_clk,
    input  logic signed [gcs_pkg::MUL_W-1:0]    i_a,
    input  logic signed [gcs_pkg::MUL_W-1:0]    i_b,
    output logic signed [gcs_pkg::PROD_W-1:0]   o_p
);

    logic signed [gcs_pkg::PROD_W-1:0] r_p;

    // Shared signed multiplier with a registered product.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: sv/gcs_chk.sv
`include "gru_cell_step_macros.svh"

module gcs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_last,
    input logic [3:0] i_out_unit_index
);

    // A word that waits stays offered.
    `GCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output word dropped while stalled")

    // Within a step the units follow one another without gaps.
    `GCS_ASSERT_NEXT(a_unit_seq, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, i_out_valid && (i_out_unit_index == 4'($past(i_out_unit_index) + 4'd1)), "unit order broken")

    // No new input while a step still has units to deliver.
    `GCS_ASSERT_SAME(a_busy_emit, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready, "input taken during emission")

    // A step's output always begins at unit zero.
    `GCS_ASSERT_SAME(a_first_unit, i_clk, i_rst_n, $rose(i_out_valid), i_out_unit_index == 4'd0, "step did not begin at unit zero")

endmodule

bind gru_cell_step gcs_chk u_gcs_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_last       (o_out.last),
    .i_out_unit_index (o_out.unit_index)
);
